// ----- rtl/core/dcq_pkg.sv -----
// ----------------------------------------------------------------------------
// dcq_pkg: shared constants and types of the deduplicating command queue
// Field widths, command and register codes, the control state type and the
// result word handed from the control logic to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package dcq_pkg;

  // Default queue depth
  localparam int DCQ_DEPTH = 32;

  // Field widths
  localparam int CMD_W  = 2;
  localparam int TYPE_W = 4;
  localparam int ARG_W  = 12;
  localparam int WORD_W = TYPE_W + ARG_W;
  localparam int FILL_W = 6;
  localparam int TICK_W = 16;

  // Saturation point of the tick counter
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_LIFO      = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROOT_TYPE = 2'd2;

  // Register reset values
  localparam logic              LIFO_RST      = 1'b0;
  localparam logic [TICK_W-1:0] INTERVAL_RST  = 16'd2000;
  localparam logic [TYPE_W-1:0] ROOT_TYPE_RST = 4'd2;

  // Control states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_FINISH
  } state_t;

  // One result item
  typedef struct packed {
    logic              has_item;
    logic [TYPE_W-1:0] out_type;
    logic [ARG_W-1:0]  out_arg;
    logic              dropped_oldest;
    logic              was_duplicate;
    logic [FILL_W-1:0] fill_level;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/dcq_if.sv -----
// ----------------------------------------------------------------------------
// dcq_if: valid/ready channels of the deduplicating command queue
// Input channel carries commands, output channel carries results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcq_in_if;
  import dcq_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TYPE_W-1:0] item_type;
  logic [ARG_W-1:0]  item_arg;

  modport source (output valid, cmd, item_type, item_arg, input ready);
  modport sink   (input valid, cmd, item_type, item_arg, output ready);
endinterface

interface dcq_out_if;
  import dcq_pkg::*;

  logic              valid;
  logic              ready;
  logic              has_item;
  logic [TYPE_W-1:0] out_type;
  logic [ARG_W-1:0]  out_arg;
  logic              dropped_oldest;
  logic              was_duplicate;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, has_item, out_type, out_arg, dropped_oldest,
                  was_duplicate, fill_level, input ready);
  modport sink   (input valid, has_item, out_type, out_arg, dropped_oldest,
                  was_duplicate, fill_level, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dcq_cell.sv -----
// ----------------------------------------------------------------------------
// dcq_cell: one storage cell of the queue ring
// Holds one command word and takes its neighbor's word when the ring moves.
// ----------------------------------------------------------------------------
`default_nettype none

module dcq_cell (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic [dcq_pkg::WORD_W-1:0] d,
  output logic      [dcq_pkg::WORD_W-1:0] q
);
  import dcq_pkg::*;

  logic [WORD_W-1:0] word;

  // Take the neighbor's word on a ring step
  always_ff @(posedge clk) begin
    if (shift) begin
      word <= d;
    end
  end

  assign q = word;

endmodule

`default_nettype wire

// ----- rtl/core/dcq_chain.sv -----
// ----------------------------------------------------------------------------
// dcq_chain: ring of storage cells
// Cell 0 holds the oldest entry. A step moves every word one cell toward
// cell 0 and wraps cell 0 into the last cell, or inserts a new word there.
// ----------------------------------------------------------------------------
`default_nettype none

module dcq_chain #(
  parameter int QUEUE_DEPTH = dcq_pkg::DCQ_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       shift,
  input  wire logic                       insert,
  input  wire logic [dcq_pkg::WORD_W-1:0] insert_word,
  output logic      [dcq_pkg::WORD_W-1:0] head_word
);
  import dcq_pkg::*;

  logic [WORD_W-1:0] cell_q [QUEUE_DEPTH];
  logic [WORD_W-1:0] wrap_word;

  // Wrap the head word around, or replace it with the inserted word
  assign wrap_word = insert ? insert_word : cell_q[0];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      dcq_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (wrap_word),
        .q     (cell_q[i])
      );
    end else begin : g_mid
      dcq_cell u_cell (
        .clk   (clk),
        .shift (shift),
        .d     (cell_q[i+1]),
        .q     (cell_q[i])
      );
    end
  end

  assign head_word = cell_q[0];

endmodule

`default_nettype wire

// ----- rtl/core/dedup_command_queue.sv -----
// ----------------------------------------------------------------------------
// dedup_command_queue: deduplicating command queue with roots generation
// Push, pop, and tick commands on a ring of cells; a push walks the whole
// ring once to find duplicates and slots the new word in on the way.
// ----------------------------------------------------------------------------
// Sequence: push and LIFO pop walk one full turn of the cell ring in ST_ROTATE,
//   then pass ST_FINISH, which loads the output register; FIFO pop, tick and
//   empty pop go from ST_IDLE straight to ST_FINISH.
// Throughput: one item at a time; the next item is taken once the result
//   is in the output register; ST_FINISH waits while that register is full.
// Reset: synchronous, active high; clears state, counters, flags and config
//   registers. Cell contents are not cleared; only written cells are ever read.
`default_nettype none

module dedup_command_queue #(
  parameter int QUEUE_DEPTH = dcq_pkg::DCQ_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  dcq_in_if.sink                              in_ch,
  dcq_out_if.source                           out_ch,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dcq_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [dcq_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [dcq_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import dcq_pkg::*;

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_W = $clog2(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUEUE_DEPTH - 1);

  // Configuration registers
  logic              lifo_mode;
  logic [TICK_W-1:0] root_interval;
  logic [TYPE_W-1:0] root_type;
  logic [REG_IDX_W-1:0] reg_idx;

  // Control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [STEP_W-1:0] step, step_next;
  logic              dup, dup_next;
  logic [CMD_W-1:0]  op, op_next;
  logic [WORD_W-1:0] word, word_next;
  logic [TICK_W-1:0] ticks, ticks_next;
  result_t           res, res_next;
  logic              out_valid, out_valid_next;
  result_t           out_res, out_res_next;

  // Ring control
  logic              ring_shift;
  logic              ring_insert;
  logic [WORD_W-1:0] head_word;

  dcq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk         (clk),
    .shift       (ring_shift),
    .insert      (ring_insert),
    .insert_word (word),
    .head_word   (head_word)
  );

  // Configuration writes
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lifo_mode     <= LIFO_RST;
      root_interval <= INTERVAL_RST;
      root_type     <= ROOT_TYPE_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_LIFO:      lifo_mode     <= pwdata[0];
        REG_INTERVAL:  root_interval <= pwdata[TICK_W-1:0];
        REG_ROOT_TYPE: root_type     <= pwdata[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Configuration reads
  always_comb begin
    case (reg_idx)
      REG_LIFO:      prdata = APB_DATA_W'(lifo_mode);
      REG_INTERVAL:  prdata = APB_DATA_W'(root_interval);
      REG_ROOT_TYPE: prdata = APB_DATA_W'(root_type);
      default:       prdata = '0;
    endcase
  end

  // Handshakes and output payload
  assign in_ch.ready           = (state == ST_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.has_item       = out_res.has_item;
  assign out_ch.out_type       = out_res.out_type;
  assign out_ch.out_arg        = out_res.out_arg;
  assign out_ch.dropped_oldest = out_res.dropped_oldest;
  assign out_ch.was_duplicate  = out_res.was_duplicate;
  assign out_ch.fill_level     = out_res.fill_level;

  // Next state and ring control
  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    dup_next       = dup;
    op_next        = op;
    word_next      = word;
    ticks_next     = ticks;
    res_next       = res;
    out_res_next   = out_res;
    out_valid_next = out_valid;
    ring_shift     = 1'b0;
    ring_insert    = 1'b0;

    // Retire the output on its transfer
    if (out_valid && out_ch.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_next   = in_ch.cmd;
          word_next = {in_ch.item_type, in_ch.item_arg};
          step_next = '0;
          dup_next  = 1'b0;
          res_next  = '0;
          case (in_ch.cmd)
            CMD_PUSH: begin
              // Drop the oldest entry of a full queue
              if (count == FULL_CNT) begin
                ring_shift              = 1'b1;
                count_next              = FULL_CNT - CNT_W'(1);
                res_next.dropped_oldest = 1'b1;
              end
              state_next = ST_ROTATE;
            end
            CMD_POP: begin
              if (count == '0) begin
                // Spontaneous roots once the interval has passed
                if (ticks > root_interval) begin
                  ticks_next        = '0;
                  res_next.has_item = 1'b1;
                  res_next.out_type = root_type;
                end
                state_next = ST_FINISH;
              end else if (lifo_mode) begin
                state_next = ST_ROTATE;
              end else begin
                // Take the head and advance the ring
                ring_shift        = 1'b1;
                count_next        = count - CNT_W'(1);
                res_next.has_item = 1'b1;
                res_next.out_type = head_word[WORD_W-1:ARG_W];
                res_next.out_arg  = head_word[ARG_W-1:0];
                state_next        = ST_FINISH;
              end
            end
            CMD_TICK: begin
              if (ticks != TICK_MAX) begin
                ticks_next = ticks + TICK_W'(1);
              end
              state_next = ST_FINISH;
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end

      ST_ROTATE: begin
        // Walk the whole ring once; position step sits in cell 0
        ring_shift = 1'b1;
        step_next  = step + STEP_W'(1);
        if (op == CMD_PUSH) begin
          if ((CNT_W'(step) < count) && (head_word == word)) begin
            dup_next = 1'b1;
          end
          if ((CNT_W'(step) == count) && !dup) begin
            ring_insert = 1'b1;
          end
        end else if (CNT_W'(step) == count - CNT_W'(1)) begin
          res_next.has_item = 1'b1;
          res_next.out_type = head_word[WORD_W-1:ARG_W];
          res_next.out_arg  = head_word[ARG_W-1:0];
        end
        if (step == STEP_LAST) begin
          step_next  = '0;
          state_next = ST_FINISH;
          if (op == CMD_PUSH) begin
            res_next.was_duplicate = dup_next;
            if (!dup_next) begin
              count_next = count + CNT_W'(1);
            end
          end else begin
            count_next = count - CNT_W'(1);
          end
        end
      end

      ST_FINISH: begin
        // Load the output register once it is free
        if (!out_valid || out_ch.ready) begin
          out_res_next            = res;
          out_res_next.fill_level = FILL_W'(count);
          out_valid_next          = 1'b1;
          state_next              = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      step      <= '0;
      dup       <= 1'b0;
      ticks     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      step      <= step_next;
      dup       <= dup_next;
      ticks     <= ticks_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op      <= op_next;
    word    <= word_next;
    res     <= res_next;
    out_res <= out_res_next;
  end

  // Queue never holds more than its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above queue depth");

  // Ring walk counter rests at zero outside a walk
  a_step_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (step == '0))
    else $error("walk counter not cleared");

  // A yielded command never carries push flags
  a_pop_flags: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res.has_item) |-> (!res.was_duplicate && !res.dropped_oldest))
    else $error("pop result carries push flags");

  // Tick count only falls by a roots restart
  a_ticks_restart: assert property (@(posedge clk) disable iff (rst)
    (ticks < $past(ticks)) |-> (ticks == '0))
    else $error("tick count fell without restart");

  // A drop leaves the queue one short of full or full again
  a_drop_level: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && res.dropped_oldest) |->
      (count == FULL_CNT || count == FULL_CNT - CNT_W'(1)))
    else $error("drop with queue not near full");

endmodule

`default_nettype wire
